/* hw/rtl/hist2d_pkg.sv */
package hist2d_pkg;

    // Fixed field widths of the word formats.
    localparam int SAMPLE_W     = 32;
    localparam int BINS_W       = 7;
    localparam int IDX_W        = 6;
    localparam int OUT_COUNT_W  = 32;
    localparam int TOTAL_W      = 32;
    localparam int OPCODE_W     = 2;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 80;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 80;
    localparam int M_TUSER_W    = 1;

    // Operation codes carried in the input tuser.
    localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS1_MIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS1_SCALE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS1_BINS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS2_MIN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS2_SCALE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS2_BINS  = 3'd5;

    // Configuration reset values.
    localparam logic [SAMPLE_W-1:0] MIN_RESET   = 32'd0;
    localparam logic [SAMPLE_W-1:0] SCALE_RESET = 32'd65536;
    localparam logic [BINS_W-1:0]   BINS_RESET  = 7'd64;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_BIN,
        ST_LOOKUP,
        ST_FINISH,
        ST_SWEEP,
        ST_CLR_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic bin_mul;
        logic lookup;
        logic finish;
        logic sweep;
        logic clear_finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                sweep_last;
        logic                out_free;
    } dp_status_t;

endpackage

/* hw/rtl/histogram_2d_binning_top.sv */
// Two-dimensional histogram engine. Each input word carries an operation in
// s_tuser: add a pair of signed Q16.16 samples, read one bin, or clear all
// bins and the running total. Each axis bins its sample as
// floor((sample - min) * scale), with scale the configured reciprocal of the
// bin width in unsigned Q16.16; a pair that lands inside the bins in use on
// both axes increments one saturating count, and the total of landed pairs
// is returned with every result for normalization in software. Every input
// word produces exactly one output word. An add or a read is binned, looked up
// and finished in turn after the word is accepted, and its result is loaded in
// the finish step; no further word is taken until then, as each add is a
// read-modify-write of the count memory (bin, look up, update). A clear sweeps
// the count memory one entry per cycle and then loads its result, with the
// running total cleared; no further word is taken until then. While an earlier
// result still waits on m_tready, the new result is held back and the block
// takes no further word. After reset the same sweep clears every entry of the
// count memory (4096 entries at the default sizes) before the first word is
// accepted; configuration writes are taken at any time, but must only be made
// while the block is idle.
module histogram_2d_binning_top #(
    parameter int MAX_BINS_ONE = 64,
    parameter int MAX_BINS_TWO = 64,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration: register index, write data, written when cfg_wr_en is high.
    input  logic                              cfg_wr_en,
    input  logic [hist2d_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hist2d_pkg::CFG_DATA_W-1:0] cfg_wr_data,

    // Input word stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: sample_one[31:0], sample_two[63:32], read_row[69:64],
    // read_col[75:70], zero padding [79:76].
    input  logic [hist2d_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0].
    input  logic [hist2d_pkg::S_TUSER_W-1:0]  s_tuser,

    // Result word stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: bin_row[5:0], bin_col[11:6], bin_count[43:12],
    // total_count[75:44], zero padding [79:76].
    output logic [hist2d_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: landed[0].
    output logic [hist2d_pkg::M_TUSER_W-1:0]  m_tuser
);

    import hist2d_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic                   out_landed;
    logic [IDX_W-1:0]       out_bin_row, out_bin_col;
    logic [OUT_COUNT_W-1:0] out_bin_count;
    logic [TOTAL_W-1:0]     out_total_count;

    // The controller sequences each word; the datapath holds the
    // configuration, the binning arithmetic, the count memory and the
    // output register.
    hist2d_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hist2d_dp #(
        .MAX_BINS_ONE (MAX_BINS_ONE),
        .MAX_BINS_TWO (MAX_BINS_TWO),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .in_opcode       (s_tuser[OPCODE_W-1:0]),
        .in_sample_one   (s_tdata[31:0]),
        .in_sample_two   (s_tdata[63:32]),
        .in_read_row     (s_tdata[69:64]),
        .in_read_col     (s_tdata[75:70]),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_landed      (out_landed),
        .out_bin_row     (out_bin_row),
        .out_bin_col     (out_bin_col),
        .out_bin_count   (out_bin_count),
        .out_total_count (out_total_count)
    );

    // Pack the result word; the upper padding bits are always zero.
    assign m_tdata = {4'd0, out_total_count, out_bin_count, out_bin_col, out_bin_row};
    assign m_tuser = out_landed;

endmodule

/* hw/rtl/hist2d_ram.sv */
module hist2d_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/hist2d_ctrl.sv */
module hist2d_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hist2d_pkg::dp_status_t status,
    output hist2d_pkg::dp_cmd_t    cmd
);

    import hist2d_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) state_next = ST_BIN;
            end
            ST_BIN: begin
                if (status.op == OP_CLEAR) state_next = ST_SWEEP;
                else state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_SWEEP: begin
                if (status.sweep_last) state_next = ST_CLR_DONE;
            end
            ST_CLR_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep = 1'b1;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_BIN: begin
                cmd.bin_mul = 1'b1;
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = status.out_free;
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
            end
            ST_CLR_DONE: begin
                cmd.clear_finish = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/hist2d_dp.sv */
module hist2d_dp #(
    parameter int MAX_BINS_ONE = 64,
    parameter int MAX_BINS_TWO = 64,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [hist2d_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hist2d_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic [hist2d_pkg::OPCODE_W-1:0]       in_opcode,
    input  logic [hist2d_pkg::SAMPLE_W-1:0]       in_sample_one,
    input  logic [hist2d_pkg::SAMPLE_W-1:0]       in_sample_two,
    input  logic [hist2d_pkg::IDX_W-1:0]          in_read_row,
    input  logic [hist2d_pkg::IDX_W-1:0]          in_read_col,
    input  hist2d_pkg::dp_cmd_t                   cmd,
    output hist2d_pkg::dp_status_t                status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_landed,
    output logic [hist2d_pkg::IDX_W-1:0]          out_bin_row,
    output logic [hist2d_pkg::IDX_W-1:0]          out_bin_col,
    output logic [hist2d_pkg::OUT_COUNT_W-1:0]    out_bin_count,
    output logic [hist2d_pkg::TOTAL_W-1:0]        out_total_count
);

    import hist2d_pkg::*;

    localparam int DEPTH  = MAX_BINS_ONE * MAX_BINS_TWO;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers.
    logic [SAMPLE_W-1:0] min1_reg, min2_reg;
    logic [SAMPLE_W-1:0] scale1_reg, scale2_reg;
    logic [BINS_W-1:0]   bins1_reg, bins2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min1_reg   <= MIN_RESET;
            scale1_reg <= SCALE_RESET;
            bins1_reg  <= BINS_RESET;
            min2_reg   <= MIN_RESET;
            scale2_reg <= SCALE_RESET;
            bins2_reg  <= BINS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_AXIS1_MIN:   min1_reg   <= cfg_wr_data;
                REG_AXIS1_SCALE: scale1_reg <= cfg_wr_data;
                REG_AXIS1_BINS:  bins1_reg  <= cfg_wr_data[BINS_W-1:0];
                REG_AXIS2_MIN:   min2_reg   <= cfg_wr_data;
                REG_AXIS2_SCALE: scale2_reg <= cfg_wr_data;
                REG_AXIS2_BINS:  bins2_reg  <= cfg_wr_data[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured item and the offsets from the lower edges (33-bit signed).
    logic [OPCODE_W-1:0] op_reg;
    logic [SAMPLE_W:0]   diff1_reg, diff2_reg;
    logic [IDX_W-1:0]    read_row_reg, read_col_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_opcode;
            diff1_reg    <= {in_sample_one[SAMPLE_W-1], in_sample_one}
                          - {min1_reg[SAMPLE_W-1], min1_reg};
            diff2_reg    <= {in_sample_two[SAMPLE_W-1], in_sample_two}
                          - {min2_reg[SAMPLE_W-1], min2_reg};
            read_row_reg <= in_read_row;
            read_col_reg <= in_read_col;
        end
    end

    // Bin index = upper half of the Q32.32 product. A negative offset misses
    // unless the scale is zero, where the product is zero anyway.
    logic [2*SAMPLE_W-1:0] prod1, prod2;
    logic [SAMPLE_W-1:0]   idx1_reg, idx2_reg;
    logic                  ok1_reg, ok2_reg;

    assign prod1 = 64'(diff1_reg[SAMPLE_W-1:0]) * 64'(scale1_reg);
    assign prod2 = 64'(diff2_reg[SAMPLE_W-1:0]) * 64'(scale2_reg);

    always_ff @(posedge aclk) begin
        if (cmd.bin_mul) begin
            idx1_reg <= prod1[2*SAMPLE_W-1:SAMPLE_W];
            idx2_reg <= prod2[2*SAMPLE_W-1:SAMPLE_W];
            ok1_reg  <= !diff1_reg[SAMPLE_W] || (scale1_reg == '0);
            ok2_reg  <= !diff2_reg[SAMPLE_W] || (scale2_reg == '0);
        end
    end

    // Range check and store address.
    logic              in1, in2, hit;
    logic              rd_ok;
    logic [BINS_W-1:0] row_sel, col_sel;
    logic [ADDR_W-1:0] addr_next;
    logic              hit_reg, rd_ok_reg;
    logic [IDX_W-1:0]  row_reg, col_reg;
    logic [ADDR_W-1:0] addr_reg;

    assign in1 = ok1_reg && (idx1_reg < 32'(bins1_reg)) && (idx1_reg < 32'(MAX_BINS_ONE));
    assign in2 = ok2_reg && (idx2_reg < 32'(bins2_reg)) && (idx2_reg < 32'(MAX_BINS_TWO));
    assign hit = in1 && in2;
    assign rd_ok = (32'(read_row_reg) < 32'(MAX_BINS_ONE))
                && (32'(read_col_reg) < 32'(MAX_BINS_TWO));

    always_comb begin
        if (op_reg == OP_ADD) begin
            row_sel = idx1_reg[BINS_W-1:0];
            col_sel = idx2_reg[BINS_W-1:0];
        end else begin
            row_sel = BINS_W'(read_row_reg);
            col_sel = BINS_W'(read_col_reg);
        end
        addr_next = ADDR_W'(32'(row_sel) * 32'(MAX_BINS_TWO) + 32'(col_sel));
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg   <= hit;
            rd_ok_reg <= rd_ok;
            row_reg   <= row_sel[IDX_W-1:0];
            col_reg   <= col_sel[IDX_W-1:0];
            addr_reg  <= addr_next;
        end
    end

    // Count store with its clearing sweep.
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                   sweep_last;
    logic [COUNT_WIDTH-1:0] ram_rdata, cnt_inc;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   add_hit;

    assign sweep_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign clr_addr_next = (cmd.sweep && sweep_last) ? '0
                         : (cmd.sweep ? clr_addr_reg + 1'b1 : clr_addr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign add_hit = (op_reg == OP_ADD) && hit_reg;
    assign cnt_inc = (ram_rdata != '1) ? ram_rdata + 1'b1 : ram_rdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = cnt_inc;
        if (cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (cmd.finish && add_hit) begin
            ram_we = 1'b1;
        end
    end

    hist2d_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.lookup),
        .rd_addr (addr_next),
        .rd_data (ram_rdata)
    );

    // Running total of landed pairs.
    logic [TOTAL_W-1:0] total_reg, total_next;

    always_comb begin
        total_next = total_reg;
        if (cmd.clear_finish) begin
            total_next = '0;
        end else if (cmd.finish && add_hit && (total_reg != '1)) begin
            total_next = total_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else begin
            total_reg <= total_next;
        end
    end

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    logic                   m_landed_reg;
    logic [IDX_W-1:0]       m_row_reg, m_col_reg;
    logic [OUT_COUNT_W-1:0] m_count_reg;
    logic [TOTAL_W-1:0]     m_total_reg;
    logic                   load_out;
    logic [COUNT_WIDTH-1:0] res_count;
    logic [63:0]            res_count_ext;
    logic                   res_landed;
    logic [IDX_W-1:0]       res_row, res_col;

    assign load_out = cmd.finish || cmd.clear_finish;

    always_comb begin
        res_landed = 1'b0;
        res_row    = '0;
        res_col    = '0;
        res_count  = '0;
        if (cmd.finish) begin
            if (add_hit) begin
                res_landed = 1'b1;
                res_row    = row_reg;
                res_col    = col_reg;
                res_count  = cnt_inc;
            end else if (op_reg == OP_READ) begin
                res_row   = row_reg;
                res_col   = col_reg;
                res_count = rd_ok_reg ? ram_rdata : '0;
            end
        end
        res_count_ext = 64'(res_count);
    end

    assign m_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_landed_reg <= res_landed;
            m_row_reg    <= res_row;
            m_col_reg    <= res_col;
            m_count_reg  <= res_count_ext[OUT_COUNT_W-1:0];
            m_total_reg  <= total_next;
        end
    end

    assign out_valid       = m_valid_reg;
    assign out_landed      = m_landed_reg;
    assign out_bin_row     = m_row_reg;
    assign out_bin_col     = m_col_reg;
    assign out_bin_count   = m_count_reg;
    assign out_total_count = m_total_reg;

    assign status.op         = op_reg;
    assign status.sweep_last = sweep_last;
    assign status.out_free   = !m_valid_reg || out_ready;

endmodule
